FILE: rtl/core/assert_macros.svh
// shared assertion macros, clocked on clk_i with active-low reset rst_ni
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define KML_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define KML_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/kml_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kml_pkg
// Types, codes and defaults shared by the k-means clustering engine.
// ----------------------------------------------------------------------------
package kml_pkg;

  localparam int MaxPointsDef   = 1024;
  localparam int MaxClustersDef = 16;
  localparam int MaxDimsDef     = 16;

  localparam logic [10:0] NumPointsRst     = 11'd1024;
  localparam logic [4:0]  NumClustersRst   = 5'd16;
  localparam logic [4:0]  NumDimsRst       = 5'd16;
  localparam logic [15:0] MaxIterationsRst = 16'd300;

  typedef enum logic [2:0] {
    ACT_LD_PT  = 3'd0,
    ACT_LD_CEN = 3'd1,
    ACT_RUN    = 3'd2,
    ACT_RD_ASG = 3'd3,
    ACT_RD_CEN = 3'd4
  } kml_action_e;

  typedef enum logic [1:0] {
    CFG_NUM_POINTS   = 2'd0,
    CFG_NUM_CLUSTERS = 2'd1,
    CFG_NUM_DIMS     = 2'd2,
    CFG_MAX_ITER     = 2'd3
  } kml_cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_RUN    = 2'd0,
    KIND_RD_ASG = 2'd1,
    KIND_RD_CEN = 2'd2
  } kml_kind_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_R_CLR, ST_R_CHK,
    ST_A_PT, ST_A_CL, ST_A_RD, ST_A_DF, ST_A_SQ, ST_A_AC, ST_A_CMP, ST_A_WR,
    ST_U_CLR, ST_U_RA, ST_U_RD, ST_U_CNT, ST_U_PI, ST_U_PW,
    ST_D_C, ST_D_CK, ST_D_RS, ST_D_ST, ST_D_WT,
    ST_DONE
  } kml_state_e;

  typedef struct packed {
    logic [2:0]         action;
    logic [9:0]         vector_index;
    logic [3:0]         dim_index;
    logic signed [15:0] coord_value;
  } kml_in_t;

  typedef struct packed {
    logic signed [15:0] coord_out;
    logic [4:0]         cluster_out;
    logic [15:0]        rounds_done;
    logic               converged;
  } kml_out_t;

  typedef struct packed {
    logic [10:0] num_points;
    logic [4:0]  num_clusters;
    logic [4:0]  num_dims;
    logic [15:0] max_iterations;
  } kml_cfg_t;

  typedef struct packed {
    logic busy;
    logic run_done;
  } kml_stat_t;

endpackage

FILE: rtl/core/kmeans_lloyd_clustering.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmeans_lloyd_clustering
// Lloyd k-means engine over signed Q8.8 points, with load, run and read
// requests and a register write port for run limits.
// ----------------------------------------------------------------------------
// channel  direction  handshake                payload
// in       sink       in_valid_i / in_ready_o   in_data_i (action, index, coord)
// out      source     out_valid_o / out_ready_i out_data_o (coord, cluster, rounds)
// cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// load and read requests are taken one per cycle while no run is active and
// the output path can take them; a read result waits in the RAM read register
// until the output register is free, then moves into it.
// a run first clears the assignment of all MAX_POINTS points, then repeats
// assign, update and divide rounds, paced by the one read and one write port
// per store and the bit-serial divider; requests wait while it runs.
// reset leaves every point unassigned; a held output stalls further requests
// only once a second result is waiting.
// ----------------------------------------------------------------------------
module kmeans_lloyd_clustering #(
  parameter int MAX_POINTS   = kml_pkg::MaxPointsDef,
  parameter int MAX_CLUSTERS = kml_pkg::MaxClustersDef,
  parameter int MAX_DIMS     = kml_pkg::MaxDimsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  kml_pkg::kml_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output kml_pkg::kml_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i
);
  import kml_pkg::*;

  kml_cfg_t    cfg_q;
  kml_stat_t   stat;
  kml_out_t    res;
  kml_out_t    out_q;
  logic        out_valid_q, out_valid_d;
  logic        pend_q, pend_d;
  logic        in_acc, move, rd_req;
  kml_action_e act;

  assign act    = kml_action_e'(in_data_i.action);
  assign rd_req = (act == ACT_RD_ASG) || (act == ACT_RD_CEN);

  // a pending read or run result moves to the output register when it is free
  assign move        = pend_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !stat.busy && (!pend_q || !out_valid_q || out_ready_i);
  assign in_acc      = in_valid_i && in_ready_o;
  assign pend_d      = (pend_q && !move) || (in_acc && rd_req) || stat.run_done;
  assign out_valid_d = move ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_points     <= NumPointsRst;
      cfg_q.num_clusters   <= NumClustersRst;
      cfg_q.num_dims       <= NumDimsRst;
      cfg_q.max_iterations <= MaxIterationsRst;
      pend_q               <= 1'b0;
      out_valid_q          <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        unique case (kml_cfg_idx_e'(cfg_index_i))
          CFG_NUM_POINTS:   cfg_q.num_points     <= cfg_data_i[10:0];
          CFG_NUM_CLUSTERS: cfg_q.num_clusters   <= cfg_data_i[4:0];
          CFG_NUM_DIMS:     cfg_q.num_dims       <= cfg_data_i[4:0];
          CFG_MAX_ITER:     cfg_q.max_iterations <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_q <= res;
    end
  end

  kml_engine #(
    .MAX_POINTS(MAX_POINTS), .MAX_CLUSTERS(MAX_CLUSTERS), .MAX_DIMS(MAX_DIMS)
  ) u_engine (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .cmd_valid_i(in_acc), .cmd_i(in_data_i),
    .stat_o(stat), .res_o(res)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/core/kml_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kml_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module kml_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    // read data holds until the next read
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/kml_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kml_div
// Radix-2 restoring divider, signed dividend by unsigned divisor,
// quotient truncated toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kml_div #(
  parameter int NUM_W = 26,
  parameter int DEN_W = 11
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0]        den_i,
  output logic                    done_o,
  output logic signed [NUM_W-1:0] quo_o
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_q, busy_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             neg_q, neg_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   rem_sh;

  assign rem_sh = {rem_q, quo_q[NUM_W-1]};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(NUM_W);
      neg_d  = num_i[NUM_W-1];
      quo_d  = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q && cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = DEN_W'(rem_sh - {1'b0, den_q});
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DEN_W-1:0];
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end
    end else if (busy_q) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign quo_o  = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

FILE: rtl/core/kml_engine.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// kml_engine
// Memory-centered k-means sequencer: point, centroid, assignment, sum and
// count RAMs with the assign / update / divide state machine around them.
// ----------------------------------------------------------------------------
module kml_engine #(
  parameter int MAX_POINTS   = 1024,
  parameter int MAX_CLUSTERS = 16,
  parameter int MAX_DIMS     = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kml_pkg::kml_cfg_t  cfg_i,
  input  logic               cmd_valid_i,
  input  kml_pkg::kml_in_t   cmd_i,
  output kml_pkg::kml_stat_t stat_o,
  output kml_pkg::kml_out_t  res_o
);
  import kml_pkg::*;

  localparam int DM_AW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int PT_AW    = $clog2(MAX_POINTS);
  localparam int CL_AW    = $clog2(MAX_CLUSTERS);
  localparam int PT_CW    = $clog2(MAX_POINTS + 1);
  localparam int CL_CW    = $clog2(MAX_CLUSTERS + 1);
  localparam int DM_CW    = $clog2(MAX_DIMS + 1);
  localparam int ASG_W    = CL_CW;
  localparam int CNT_W    = PT_CW;
  localparam int SUM_W    = 16 + PT_AW;
  localparam int DIST_W   = 33 + DM_AW;
  localparam int PT_DEPTH = MAX_POINTS << DM_AW;
  localparam int CN_DEPTH = MAX_CLUSTERS << DM_AW;
  localparam int PTA_W    = PT_AW + DM_AW;
  localparam int CNA_W    = CL_AW + DM_AW;
  localparam logic [ASG_W-1:0] Unassigned = ASG_W'(MAX_CLUSTERS);

  // centroid index of a vector index, by compare and subtract
  function automatic logic [CL_AW-1:0] cen_index(input logic [9:0] v);
    logic [31:0] r;
    r = 32'(v);
    for (int k = 9; k >= 0; k--) begin
      if (r >= (32'(MAX_CLUSTERS) << k)) begin
        r = r - (32'(MAX_CLUSTERS) << k);
      end
    end
    return r[CL_AW-1:0];
  endfunction

  kml_state_e state_q, state_d;
  kml_kind_e  kind_q;
  logic       rng_q;

  logic [PT_CW-1:0] i_q;
  logic [CL_CW-1:0] c_q;
  logic [DM_CW-1:0] j_q;
  logic [CNA_W-1:0] clr_q;
  logic [CL_AW-1:0] best_q, a_q;
  logic [CNT_W-1:0] cnt_q;
  logic [15:0]      left_q, rounds_q;
  logic             moved_q, conv_q, ever_q;

  logic signed [16:0] diff_q;
  logic [32:0]        sq_q;
  logic [DIST_W-1:0]  acc_q, best_d_q;
  logic signed [33:0] prod;

  // memory ports
  logic             pt_we, pt_re;
  logic [PTA_W-1:0] pt_waddr, pt_raddr;
  logic [15:0]      pt_wdata, pt_rdata;
  logic             cn_we, cn_re;
  logic [CNA_W-1:0] cn_waddr, cn_raddr;
  logic [15:0]      cn_wdata, cn_rdata;
  logic             as_we, as_re;
  logic [PT_AW-1:0] as_waddr, as_raddr;
  logic [ASG_W-1:0] as_wdata, as_rdata;
  logic             sm_we, sm_re;
  logic [CNA_W-1:0] sm_waddr, sm_raddr;
  logic [SUM_W-1:0] sm_wdata, sm_rdata;
  logic             ct_we, ct_re;
  logic [CL_AW-1:0] ct_waddr, ct_raddr;
  logic [CNT_W-1:0] ct_wdata, ct_rdata;

  logic                    div_start, div_done;
  logic signed [SUM_W-1:0] div_quo;

  // run limits, clamped
  logic [31:0]      np32, nc32, nd32;
  logic [PT_CW-1:0] np;
  logic [CL_CW-1:0] nc;
  logic [DM_CW-1:0] nd;
  logic             i_last, c_last, j_last, i_sweep_last, clr_last, a_member;
  logic             round_end, run_go;

  // host decode
  kml_action_e      act;
  logic [31:0]      vidx32, didx32;
  logic             pt_rng, dm_rng, vp_rng;
  logic [CL_AW-1:0] cidx;

  assign np32 = (cfg_i.num_points == '0) ? 32'd1 :
                (32'(cfg_i.num_points) > 32'(MAX_POINTS)) ? 32'(MAX_POINTS) :
                32'(cfg_i.num_points);
  assign nc32 = (cfg_i.num_clusters == '0) ? 32'd1 :
                (32'(cfg_i.num_clusters) > 32'(MAX_CLUSTERS)) ? 32'(MAX_CLUSTERS) :
                32'(cfg_i.num_clusters);
  assign nd32 = (cfg_i.num_dims == '0) ? 32'd1 :
                (32'(cfg_i.num_dims) > 32'(MAX_DIMS)) ? 32'(MAX_DIMS) :
                32'(cfg_i.num_dims);
  assign np = np32[PT_CW-1:0];
  assign nc = nc32[CL_CW-1:0];
  assign nd = nd32[DM_CW-1:0];

  assign i_last       = PT_CW'(i_q + 1'b1) == np;
  assign c_last       = CL_CW'(c_q + 1'b1) == nc;
  assign j_last       = DM_CW'(j_q + 1'b1) == nd;
  assign i_sweep_last = i_q == PT_CW'(MAX_POINTS - 1);
  assign clr_last     = clr_q == CNA_W'(CN_DEPTH - 1);
  assign a_member     = as_rdata < nc;
  assign run_go       = (left_q != '0) && moved_q;
  assign round_end    = ((state_q == ST_D_CK) && (ct_rdata == '0) && c_last) ||
                        ((state_q == ST_D_WT) && div_done && j_last && c_last);

  assign act    = kml_action_e'(cmd_i.action);
  assign vidx32 = 32'(cmd_i.vector_index);
  assign didx32 = 32'(cmd_i.dim_index);
  assign dm_rng = didx32 < 32'(MAX_DIMS);
  assign vp_rng = vidx32 < 32'(MAX_POINTS);
  assign pt_rng = vp_rng && dm_rng;
  assign cidx   = cen_index(cmd_i.vector_index);

  assign prod = diff_q * diff_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (cmd_valid_i && act == ACT_RUN) state_d = ST_R_CLR;
      ST_R_CLR: if (i_sweep_last) state_d = ST_R_CHK;
      ST_R_CHK: state_d = run_go ? ST_A_PT : ST_DONE;
      ST_A_PT:  state_d = ST_A_CL;
      ST_A_CL:  state_d = ST_A_RD;
      ST_A_RD:  state_d = ST_A_DF;
      ST_A_DF:  state_d = ST_A_SQ;
      ST_A_SQ:  state_d = ST_A_AC;
      ST_A_AC:  state_d = j_last ? ST_A_CMP : ST_A_RD;
      ST_A_CMP: state_d = c_last ? ST_A_WR : ST_A_CL;
      ST_A_WR:  state_d = i_last ? ST_U_CLR : ST_A_PT;
      ST_U_CLR: if (clr_last) state_d = ST_U_RA;
      ST_U_RA:  state_d = ST_U_RD;
      ST_U_RD:  state_d = a_member ? ST_U_CNT : (i_last ? ST_D_C : ST_U_RA);
      ST_U_CNT: state_d = ST_U_PI;
      ST_U_PI:  state_d = ST_U_PW;
      ST_U_PW:  state_d = !j_last ? ST_U_PI : (i_last ? ST_D_C : ST_U_RA);
      ST_D_C:   state_d = ST_D_CK;
      ST_D_CK: begin
        if (ct_rdata != '0) state_d = ST_D_RS;
        else                state_d = c_last ? ST_R_CHK : ST_D_C;
      end
      ST_D_RS:  state_d = ST_D_ST;
      ST_D_ST:  state_d = ST_D_WT;
      ST_D_WT: begin
        if (div_done) begin
          if (!j_last)     state_d = ST_D_RS;
          else if (c_last) state_d = ST_R_CHK;
          else             state_d = ST_D_C;
        end
      end
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    pt_we = 1'b0; pt_waddr = '0; pt_wdata = '0; pt_re = 1'b0; pt_raddr = '0;
    cn_we = 1'b0; cn_waddr = '0; cn_wdata = '0; cn_re = 1'b0; cn_raddr = '0;
    as_we = 1'b0; as_waddr = '0; as_wdata = '0; as_re = 1'b0; as_raddr = '0;
    sm_we = 1'b0; sm_waddr = '0; sm_wdata = '0; sm_re = 1'b0; sm_raddr = '0;
    ct_we = 1'b0; ct_waddr = '0; ct_wdata = '0; ct_re = 1'b0; ct_raddr = '0;
    div_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (act)
            ACT_LD_PT: begin
              pt_we    = pt_rng;
              pt_waddr = {vidx32[PT_AW-1:0], didx32[DM_AW-1:0]};
              pt_wdata = cmd_i.coord_value;
            end
            ACT_LD_CEN: begin
              cn_we    = dm_rng;
              cn_waddr = {cidx, didx32[DM_AW-1:0]};
              cn_wdata = cmd_i.coord_value;
            end
            ACT_RD_ASG: begin
              as_re    = 1'b1;
              as_raddr = vidx32[PT_AW-1:0];
            end
            ACT_RD_CEN: begin
              cn_re    = 1'b1;
              cn_raddr = {cidx, didx32[DM_AW-1:0]};
            end
            default: ;
          endcase
        end
      end
      ST_R_CLR: begin
        as_we    = 1'b1;
        as_waddr = i_q[PT_AW-1:0];
        as_wdata = Unassigned;
      end
      ST_A_PT: begin
        as_re    = 1'b1;
        as_raddr = i_q[PT_AW-1:0];
      end
      ST_A_RD: begin
        pt_re    = 1'b1;
        pt_raddr = {i_q[PT_AW-1:0], j_q[DM_AW-1:0]};
        cn_re    = 1'b1;
        cn_raddr = {c_q[CL_AW-1:0], j_q[DM_AW-1:0]};
      end
      ST_A_WR: begin
        as_we    = 1'b1;
        as_waddr = i_q[PT_AW-1:0];
        as_wdata = ASG_W'(best_q);
      end
      ST_U_CLR: begin
        sm_we    = 1'b1;
        sm_waddr = clr_q;
        ct_we    = clr_q[DM_AW-1:0] == '0;
        ct_waddr = clr_q[CNA_W-1:DM_AW];
      end
      ST_U_RA: begin
        as_re    = 1'b1;
        as_raddr = i_q[PT_AW-1:0];
      end
      ST_U_RD: begin
        ct_re    = a_member;
        ct_raddr = as_rdata[CL_AW-1:0];
      end
      ST_U_CNT: begin
        ct_we    = 1'b1;
        ct_waddr = a_q;
        ct_wdata = ct_rdata + 1'b1;
      end
      ST_U_PI: begin
        pt_re    = 1'b1;
        pt_raddr = {i_q[PT_AW-1:0], j_q[DM_AW-1:0]};
        sm_re    = 1'b1;
        sm_raddr = {a_q, j_q[DM_AW-1:0]};
      end
      ST_U_PW: begin
        sm_we    = 1'b1;
        sm_waddr = {a_q, j_q[DM_AW-1:0]};
        sm_wdata = sm_rdata + {{(SUM_W-16){pt_rdata[15]}}, pt_rdata};
      end
      ST_D_C: begin
        ct_re    = 1'b1;
        ct_raddr = c_q[CL_AW-1:0];
      end
      ST_D_RS: begin
        sm_re    = 1'b1;
        sm_raddr = {c_q[CL_AW-1:0], j_q[DM_AW-1:0]};
      end
      ST_D_ST: div_start = 1'b1;
      ST_D_WT: begin
        cn_we    = div_done;
        cn_waddr = {c_q[CL_AW-1:0], j_q[DM_AW-1:0]};
        cn_wdata = div_quo[15:0];
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      kind_q   <= KIND_RUN;
      rng_q    <= 1'b0;
      i_q      <= '0;
      c_q      <= '0;
      j_q      <= '0;
      clr_q    <= '0;
      a_q      <= '0;
      left_q   <= '0;
      rounds_q <= '0;
      moved_q  <= 1'b0;
      conv_q   <= 1'b0;
      ever_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (round_end) begin
        left_q   <= left_q - 1'b1;
        rounds_q <= rounds_q + 1'b1;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            unique case (act)
              ACT_RUN: begin
                kind_q <= KIND_RUN;
                i_q    <= '0;
                ever_q <= 1'b1;
              end
              ACT_RD_ASG: begin
                kind_q <= KIND_RD_ASG;
                rng_q  <= vp_rng;
              end
              ACT_RD_CEN: begin
                kind_q <= KIND_RD_CEN;
                rng_q  <= dm_rng;
              end
              default: ;
            endcase
          end
        end
        ST_R_CLR: begin
          i_q <= i_q + 1'b1;
          if (i_sweep_last) begin
            left_q   <= cfg_i.max_iterations;
            rounds_q <= '0;
            moved_q  <= 1'b1;
          end
        end
        ST_R_CHK: begin
          i_q <= '0;
          if (run_go) moved_q <= 1'b0;
          else        conv_q  <= !moved_q;
        end
        ST_A_PT:  c_q <= '0;
        ST_A_CL:  j_q <= '0;
        ST_A_AC:  j_q <= j_q + 1'b1;
        ST_A_CMP: c_q <= c_q + 1'b1;
        ST_A_WR: begin
          if (as_rdata != ASG_W'(best_q)) moved_q <= 1'b1;
          i_q   <= i_q + 1'b1;
          clr_q <= '0;
        end
        ST_U_CLR: begin
          clr_q <= clr_q + 1'b1;
          i_q   <= '0;
        end
        ST_U_RD: begin
          a_q <= as_rdata[CL_AW-1:0];
          j_q <= '0;
          if (!a_member) begin
            i_q <= i_q + 1'b1;
            c_q <= '0;
          end
        end
        ST_U_PW: begin
          j_q <= j_q + 1'b1;
          if (j_last) begin
            i_q <= i_q + 1'b1;
            c_q <= '0;
          end
        end
        ST_D_CK: begin
          j_q <= '0;
          if (ct_rdata == '0) c_q <= c_q + 1'b1;
        end
        ST_D_WT: begin
          if (div_done) begin
            j_q <= j_q + 1'b1;
            if (j_last) begin
              c_q <= c_q + 1'b1;
              j_q <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_A_CL: acc_q  <= '0;
      ST_A_DF: diff_q <= $signed({pt_rdata[15], pt_rdata}) - $signed({cn_rdata[15], cn_rdata});
      ST_A_SQ: sq_q   <= prod[32:0];
      ST_A_AC: acc_q  <= acc_q + DIST_W'(sq_q);
      ST_A_CMP: begin
        // strict compare keeps the lowest index on ties
        if (c_q == '0 || acc_q < best_d_q) begin
          best_q   <= c_q[CL_AW-1:0];
          best_d_q <= acc_q;
        end
      end
      ST_D_CK: cnt_q <= ct_rdata;
      default: ;
    endcase
  end

  kml_ram #(.WIDTH(16), .DEPTH(PT_DEPTH)) u_pt_ram (
    .clk_i, .we_i(pt_we), .waddr_i(pt_waddr), .wdata_i(pt_wdata),
    .re_i(pt_re), .raddr_i(pt_raddr), .rdata_o(pt_rdata)
  );

  kml_ram #(.WIDTH(16), .DEPTH(CN_DEPTH)) u_cen_ram (
    .clk_i, .we_i(cn_we), .waddr_i(cn_waddr), .wdata_i(cn_wdata),
    .re_i(cn_re), .raddr_i(cn_raddr), .rdata_o(cn_rdata)
  );

  kml_ram #(.WIDTH(ASG_W), .DEPTH(MAX_POINTS)) u_asg_ram (
    .clk_i, .we_i(as_we), .waddr_i(as_waddr), .wdata_i(as_wdata),
    .re_i(as_re), .raddr_i(as_raddr), .rdata_o(as_rdata)
  );

  kml_ram #(.WIDTH(SUM_W), .DEPTH(CN_DEPTH)) u_sum_ram (
    .clk_i, .we_i(sm_we), .waddr_i(sm_waddr), .wdata_i(sm_wdata),
    .re_i(sm_re), .raddr_i(sm_raddr), .rdata_o(sm_rdata)
  );

  kml_ram #(.WIDTH(CNT_W), .DEPTH(MAX_CLUSTERS)) u_cnt_ram (
    .clk_i, .we_i(ct_we), .waddr_i(ct_waddr), .wdata_i(ct_wdata),
    .re_i(ct_re), .raddr_i(ct_raddr), .rdata_o(ct_rdata)
  );

  kml_div #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i($signed(sm_rdata)), .den_i(cnt_q),
    .done_o(div_done), .quo_o(div_quo)
  );

  assign stat_o.busy     = state_q != ST_IDLE;
  assign stat_o.run_done = state_q == ST_DONE;

  always_comb begin
    res_o.coord_out   = '0;
    res_o.cluster_out = 5'(Unassigned);
    res_o.rounds_done = rounds_q;
    res_o.converged   = conv_q;
    unique case (kind_q)
      KIND_RD_ASG: if (rng_q && ever_q) res_o.cluster_out = 5'(as_rdata);
      KIND_RD_CEN: if (rng_q) res_o.coord_out = cn_rdata;
      default: ;
    endcase
  end

  `KML_ASSERT(a_cmd_idle, !cmd_valid_i || state_q == ST_IDLE, "request while run active")
  `KML_ASSERT(a_member_rng, state_q != ST_U_PW || a_q < nc, "member outside cluster range")
  `KML_ASSERT(a_div_wait, !div_done || state_q == ST_D_WT, "quotient with no waiting write")
  `KML_ASSERT_NEXT(a_conv_end, state_q == ST_R_CHK && !run_go && left_q != '0, conv_q, "run stopped early without convergence")

endmodule
